>>> rtl/lom_pkg.sv
// Package for the limit order matcher: request and result structs, side codes.
// No dependencies; used by every module of the block.
`default_nettype none
package lom_pkg;

	localparam int PriceW = 16;
	localparam int QtyW   = 16;
	localparam int GainW  = 32;
	localparam int TotW   = 48;
	localparam int CntW   = 5;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [QtyW-1:0]   order_quantity;
		logic [PriceW-1:0] limit_price;
	} req_t;

	typedef struct packed {
		logic              is_fill;
		logic [PriceW-1:0] fill_price;
		logic [QtyW-1:0]   fill_quantity;
		logic [GainW-1:0]  fill_spread_gain;
		logic [TotW-1:0]   total_gain;
		logic [TotW-1:0]   total_traded;
		logic [CntW-1:0]   buys_resting;
		logic [CntW-1:0]   sells_resting;
		logic              remainder_dropped;
		logic              last_result;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture the request
		logic scan_start; // reset the best-entry search
		logic scan_step;  // examine one book entry
		logic fill;       // perform the trade at the found entry
		logic shift;      // close the gap left by one removed entry
		logic rest;       // append the remainder to the own book
		logic emit_fill;  // build a fill result
		logic emit_sum;   // build the summary result
	} lom_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scan_done;  // search covered every live entry
		logic can_fill;   // best entry crosses and quantity remains
		logic removed;    // last fill emptied its entry
		logic shift_done; // gap has reached the book end
	} lom_sts_t;

endpackage
`default_nettype wire

>>> rtl/lom_datapath.sv
// Datapath of the limit order matcher: books, counters, search, fill arithmetic.
// Depends on lom_pkg; driven by lom_ctrl.
`default_nettype none
module lom_datapath #(
	parameter int BOOK_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lom_pkg::req_t     req,
	input  wire lom_pkg::lom_cmd_t cmd,
	output lom_pkg::lom_sts_t      sts,
	output lom_pkg::rsp_t          rsp
);
	import lom_pkg::*;

	localparam int IdxW = $clog2(BOOK_DEPTH);
	localparam int NW   = $clog2(BOOK_DEPTH + 1);
	localparam logic [TotW-1:0] Max48 = {TotW{1'b1}};

	logic [PriceW+QtyW-1:0] buy_mem [BOOK_DEPTH];
	logic [PriceW+QtyW-1:0] sell_mem [BOOK_DEPTH];
	logic [NW-1:0]     buy_cnt_q, sell_cnt_q;
	logic [TotW-1:0]   gain_acc_q, trad_acc_q;
	logic              side_q;
	logic [QtyW-1:0]   qty_q;
	logic [PriceW-1:0] price_q;
	logic [IdxW-1:0]   scan_q, best_q;
	logic [IdxW-1:0]   rd_addr;
	logic [NW-1:0]     pos_q;
	logic              have_q, removed_q;
	logic [PriceW+QtyW-1:0] best_ent_q, rd_q;
	logic [PriceW-1:0] fp_q;
	logic [QtyW-1:0]   ft_q;
	logic [GainW-1:0]  fg_q;
	logic [NW-1:0]     opp_cnt, own_cnt;
	logic [PriceW-1:0] bp, rp, gap;
	logic [QtyW-1:0]   bq, tq;
	logic              better, crosses;
	logic [TotW:0]     gsum, tsum;

	assign opp_cnt = (side_q == SIDE_BUY) ? sell_cnt_q : buy_cnt_q;
	assign own_cnt = (side_q == SIDE_BUY) ? buy_cnt_q : sell_cnt_q;

	// Read one entry of the opposite book a cycle; a new search starts at entry zero.
	assign rd_addr = cmd.scan_start ? '0 : scan_q;

	always_ff @(posedge clk) begin
		rd_q <= (side_q == SIDE_BUY) ? sell_mem[rd_addr] : buy_mem[rd_addr];
	end

	assign rp = rd_q[PriceW+QtyW-1:QtyW];
	assign bp = best_ent_q[PriceW+QtyW-1:QtyW];
	assign bq = best_ent_q[QtyW-1:0];
	assign better = !have_q || ((side_q == SIDE_BUY) ? (rp < bp) : (rp > bp));
	assign crosses = (side_q == SIDE_BUY) ? (bp <= price_q) : (bp >= price_q);
	assign gap = (side_q == SIDE_BUY) ? (price_q - bp) : (bp - price_q);
	assign tq = (qty_q < bq) ? qty_q : bq;
	assign gsum = {1'b0, gain_acc_q} + {{(TotW+1-GainW){1'b0}}, fg_q};
	assign tsum = {1'b0, trad_acc_q} + {{(TotW+1-QtyW){1'b0}}, ft_q};

	assign sts.scan_done = (pos_q == opp_cnt);
	assign sts.can_fill  = (qty_q != '0) && (opp_cnt != '0) && crosses;
	assign sts.removed   = removed_q;
	assign sts.shift_done = (NW'(best_q) + NW'(1)) >= opp_cnt;

	// Search, fill and book maintenance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buy_cnt_q  <= '0;
			sell_cnt_q <= '0;
			gain_acc_q <= '0;
			trad_acc_q <= '0;
			have_q     <= 1'b0;
			removed_q  <= 1'b0;
			scan_q     <= '0;
			pos_q      <= '0;
		end else begin
			if (cmd.load) begin
				side_q  <= req.req_type;
				qty_q   <= req.order_quantity;
				price_q <= req.limit_price;
			end
			if (cmd.scan_start) begin
				have_q <= 1'b0;
				scan_q <= IdxW'(1);
				pos_q  <= '0;
			end
			if (cmd.scan_step) begin
				// pos_q trails scan_q by one: rd_q holds entry pos_q
				if (better) begin
					best_ent_q <= rd_q;
					best_q     <= pos_q[IdxW-1:0];
				end
				have_q <= 1'b1;
				pos_q  <= pos_q + 1'b1;
				if (NW'(scan_q) < NW'(BOOK_DEPTH - 1))
					scan_q <= scan_q + 1'b1;
			end else if (!cmd.scan_start) begin
				scan_q <= (cmd.shift) ? best_q + 1'b1 : scan_q;
			end
			if (cmd.fill) begin
				fp_q   <= bp;
				ft_q   <= tq;
				fg_q   <= {{(GainW-PriceW){1'b0}}, gap} * {{(GainW-QtyW){1'b0}}, tq};
				qty_q  <= qty_q - tq;
				removed_q <= (tq == bq);
				if (side_q == SIDE_BUY)
					sell_mem[best_q] <= {bp, bq - tq};
				else
					buy_mem[best_q] <= {bp, bq - tq};
			end
			if (cmd.emit_fill) begin
				gain_acc_q <= gsum[TotW] ? Max48 : gsum[TotW-1:0];
				trad_acc_q <= tsum[TotW] ? Max48 : tsum[TotW-1:0];
				if (removed_q && sts.shift_done) begin
					if (side_q == SIDE_BUY) sell_cnt_q <= sell_cnt_q - 1'b1;
					else                    buy_cnt_q  <= buy_cnt_q - 1'b1;
				end
			end
			// Move the next entry down by one; the last step drops the count.
			if (cmd.shift) begin
				if (side_q == SIDE_BUY)
					sell_mem[best_q] <= sell_mem[best_q+1'b1];
				else
					buy_mem[best_q] <= buy_mem[best_q+1'b1];
				best_q <= best_q + 1'b1;
				if ((NW'(best_q) + NW'(2)) >= opp_cnt) begin
					if (side_q == SIDE_BUY) sell_cnt_q <= sell_cnt_q - 1'b1;
					else                    buy_cnt_q  <= buy_cnt_q - 1'b1;
				end
			end
			if (cmd.rest && qty_q != '0 && own_cnt < NW'(BOOK_DEPTH)) begin
				if (side_q == SIDE_BUY) begin
					buy_mem[buy_cnt_q[IdxW-1:0]] <= {price_q, qty_q};
					buy_cnt_q <= buy_cnt_q + 1'b1;
				end else begin
					sell_mem[sell_cnt_q[IdxW-1:0]] <= {price_q, qty_q};
					sell_cnt_q <= sell_cnt_q + 1'b1;
				end
			end
		end
	end

	// Build the outgoing result; a used-up entry already counts as gone.
	always_comb begin
		rsp = '0;
		rsp.total_gain    = gain_acc_q;
		rsp.total_traded  = trad_acc_q;
		rsp.buys_resting  = CntW'(buy_cnt_q);
		rsp.sells_resting = CntW'(sell_cnt_q);
		if (cmd.emit_fill) begin
			rsp.is_fill          = 1'b1;
			rsp.fill_price       = fp_q;
			rsp.fill_quantity    = ft_q;
			rsp.fill_spread_gain = fg_q;
			rsp.total_gain       = gsum[TotW] ? Max48 : gsum[TotW-1:0];
			rsp.total_traded     = tsum[TotW] ? Max48 : tsum[TotW-1:0];
			if (removed_q) begin
				if (side_q == SIDE_BUY) rsp.sells_resting = CntW'(sell_cnt_q - 1'b1);
				else                    rsp.buys_resting  = CntW'(buy_cnt_q - 1'b1);
			end
		end else begin
			rsp.last_result = 1'b1;
			rsp.remainder_dropped = (qty_q != '0) && (own_cnt >= NW'(BOOK_DEPTH));
			if ((qty_q != '0) && (own_cnt < NW'(BOOK_DEPTH))) begin
				if (side_q == SIDE_BUY) rsp.buys_resting  = CntW'(buy_cnt_q + 1'b1);
				else                    rsp.sells_resting = CntW'(sell_cnt_q + 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/lom_ctrl.sv
// Controller of the limit order matcher: sequences search, fill, shift, result.
// Depends on lom_pkg; drives lom_datapath.
`default_nettype none
module lom_ctrl #(
	parameter int BOOK_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire lom_pkg::lom_sts_t sts,
	output lom_pkg::lom_cmd_t      cmd,
	output logic                   out_load
);
	import lom_pkg::*;

	localparam int FW = $clog2(BOOK_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PRIME, ST_SCAN, ST_DECIDE, ST_FILL, ST_SHIFT, ST_OUT
	} state_t;

	state_t        state_q;
	logic [FW-1:0] fills_q;
	logic          is_sum_q;

	// The next request waits until the summary has left the output register.
	assign in_stall = (state_q != ST_IDLE) || out_valid;

	always_comb begin
		cmd = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   cmd.load = in_valid && !in_stall;
			ST_PRIME:  cmd.scan_start = 1'b1;
			ST_SCAN:   cmd.scan_step = !sts.scan_done;
			ST_DECIDE: begin end
			ST_FILL:   cmd.fill = 1'b1;
			ST_SHIFT:  cmd.shift = !sts.shift_done;
			ST_OUT: begin
				// Issue the result once, in the cycle it enters the output register.
				cmd.emit_fill = !is_sum_q && !out_valid;
				cmd.emit_sum  = is_sum_q && !out_valid;
				cmd.rest      = is_sum_q && !out_valid;
				out_load      = !out_valid;
			end
			default: begin end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fills_q   <= '0;
			is_sum_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (cmd.load) begin
					state_q <= ST_PRIME;
					fills_q <= '0;
				end
				ST_PRIME: state_q <= ST_SCAN;
				ST_SCAN: if (sts.scan_done) state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (sts.can_fill && fills_q < FW'(BOOK_DEPTH)) begin
						state_q <= ST_FILL;
					end else begin
						is_sum_q <= 1'b1;
						state_q  <= ST_OUT;
					end
				end
				ST_FILL: begin
					fills_q  <= fills_q + 1'b1;
					is_sum_q <= 1'b0;
					state_q  <= ST_OUT;
				end
				ST_OUT: if (!out_valid) begin
					out_valid <= 1'b1;
					if (is_sum_q) state_q <= ST_IDLE;
					else if (sts.removed && !sts.shift_done) state_q <= ST_SHIFT;
					else state_q <= ST_PRIME;
				end
				ST_SHIFT: if (sts.shift_done) state_q <= ST_PRIME;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fill, cmd.shift, cmd.scan_step, cmd.emit_fill, cmd.emit_sum}))
		else $error("conflicting datapath commands");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("request taken while busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fills_q <= FW'(BOOK_DEPTH))
		else $error("fill count over book depth");

endmodule
`default_nettype wire

>>> rtl/limit_order_matcher_core.sv
// Limit order matcher top level: joins lom_ctrl and lom_datapath, holds the result register.
// Depends on lom_pkg, lom_ctrl, lom_datapath.
//
// Usage: one request channel (req, req_valid, req_stall) carries an order
// (side, quantity, limit price). One result channel (rsp, rsp_valid,
// rsp_stall) gives one fill record per trade, then one closing summary.
// Each fill takes a search of the opposite book, one entry a cycle, a
// fill step, an output step, and when a resting order is used up a
// compaction that moves each entry behind it down by one. A new request
// is taken after the summary has been handed over. Reset empties both
// books and clears the totals. A stall on the result side holds the
// result register; the sequencer runs on and waits at its next result,
// or in idle after the summary, until the held result is taken.
`default_nettype none
module limit_order_matcher_core #(
	parameter int BOOK_DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lom_pkg::req_t req,
	input  wire logic          req_valid,
	output logic               req_stall,
	output lom_pkg::rsp_t      rsp,
	output logic               rsp_valid,
	input  wire logic          rsp_stall
);
	import lom_pkg::*;

	lom_cmd_t cmd;
	lom_sts_t sts;
	rsp_t     rsp_next;
	logic     out_load;

	lom_ctrl #(.BOOK_DEPTH(BOOK_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req_valid), .in_stall(req_stall),
		.out_valid(rsp_valid), .out_stall(rsp_stall), .sts(sts), .cmd(cmd),
		.out_load(out_load)
	);

	lom_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp_next)
	);

	// Hold each result until the receiver takes it.
	always_ff @(posedge clk) begin
		if (out_load) rsp <= rsp_next;
	end

endmodule
`default_nettype wire
